>>> design/suvm_pkg.sv
// package for the spherical uv mapping core: widths, constants and the arctangent table
package suvm_pkg;

    // pipeline configuration
    localparam int CORDIC_STAGES   = 18;
    localparam int COORD_FRAC_BITS = 16;

    // field widths
    localparam int IN_W  = 32;
    localparam int OUT_W = 17;

    // datapath widths: differences, cordic x/y, angle accumulator
    localparam int D_W  = IN_W + 1;
    localparam int XY_W = D_W + 5;
    localparam int Z_W  = 34;
    localparam int G_W  = 31;
    localparam int P_W  = D_W + G_W;
    localparam int KY_W = P_W - 30;

    // cordic gain in q30 and angle constants (pi is 2^31)
    localparam logic [G_W-1:0]     GAIN_Q30  = 31'd1768195363;
    localparam logic signed [Z_W-1:0] QUARTER = 34'sd1073741824;
    localparam logic signed [Z_W:0]   HALF_TURN = 35'sd2147483648;

    // output rounding and shifts
    localparam int U_SHIFT = 32 - COORD_FRAC_BITS;
    localparam int V_SHIFT = 31 - COORD_FRAC_BITS;
    localparam logic [Z_W:0] U_ROUND = 35'(64'd1 << (31 - COORD_FRAC_BITS));
    localparam logic [Z_W:0] V_ROUND = 35'(64'd1 << (30 - COORD_FRAC_BITS));
    localparam logic [OUT_W-1:0] HALF_CODE =
        OUT_W'((64'd1 << (COORD_FRAC_BITS - 1)) & 64'h1FFFF);

    // round(atan(2^-i) * 2^31 / pi)
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

endpackage

>>> design/sphere_uv_mapping_core.sv
// top level of the spherical uv mapping core: differences, two cordic pipelines, output stage
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  in      | i_valid / o_ready  | i_point_x/y/z, i_center_x/y/z (signed q16.16)
//  out     | o_valid / i_ready  | o_u_coord, o_v_coord (unsigned q1.16, 17 bits)
//
// one transaction enters per cycle while o_ready is high; the path runs through
// the difference stage, the pre-rotation/gain multiply stage, one register per
// iteration of each vectoring cordic, and the output register.
// reset (synchronous, active low) clears the valid bits only.
// a stall at the output freezes every stage together, so nothing is lost or repeated.
module sphere_uv_mapping_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [suvm_pkg::IN_W-1:0] i_point_x,
    input  logic signed [suvm_pkg::IN_W-1:0] i_point_y,
    input  logic signed [suvm_pkg::IN_W-1:0] i_point_z,
    input  logic signed [suvm_pkg::IN_W-1:0] i_center_x,
    input  logic signed [suvm_pkg::IN_W-1:0] i_center_y,
    input  logic signed [suvm_pkg::IN_W-1:0] i_center_z,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [suvm_pkg::OUT_W-1:0]     o_u_coord,
    output logic [suvm_pkg::OUT_W-1:0]     o_v_coord
);
    import suvm_pkg::*;

    localparam int N = CORDIC_STAGES;

    // pipeline advance
    logic r_o_valid;
    logic w_adv;
    assign w_adv   = !r_o_valid || i_ready;
    assign o_ready = w_adv;

    // difference stage
    logic                  r_s0_vld;
    logic signed [D_W-1:0] r_s0_dx, r_s0_dy, r_s0_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_adv) begin
            r_s0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_dx <= D_W'(i_point_x) - D_W'(i_center_x);
            r_s0_dy <= D_W'(i_point_y) - D_W'(i_center_y);
            r_s0_dz <= D_W'(i_point_z) - D_W'(i_center_z);
        end
    end

    // pre-rotation into the right half plane and gain multiply of |dy|
    logic                   r_c1_vld  [0:N];
    logic                   r_c1_pole [0:N];
    logic                   r_c1_zero [0:N];
    logic signed [XY_W-1:0] r_c1_x    [0:N];
    logic signed [XY_W-1:0] r_c1_y    [0:N];
    logic signed [Z_W-1:0]  r_c1_z    [0:N];
    logic signed [XY_W-1:0] r_ky      [1:N];
    logic [P_W-1:0]         r_s1_prod;
    logic                   r_s1_neg;

    logic signed [XY_W-1:0] n_x0, n_y0;
    logic signed [Z_W-1:0]  n_z0;
    logic [D_W-1:0]         w_aby;
    logic                   w_pole;

    always_comb begin
        n_x0 = XY_W'(r_s0_dz);
        n_y0 = XY_W'(r_s0_dx);
        n_z0 = '0;
        if (r_s0_dz < 0) begin
            if (r_s0_dx >= 0) begin
                n_x0 = XY_W'(r_s0_dx);
                n_y0 = -XY_W'(r_s0_dz);
                n_z0 = QUARTER;
            end else begin
                n_x0 = -XY_W'(r_s0_dx);
                n_y0 = XY_W'(r_s0_dz);
                n_z0 = -QUARTER;
            end
        end
        w_aby  = r_s0_dy[D_W-1] ? D_W'(-r_s0_dy) : D_W'(r_s0_dy);
        w_pole = (r_s0_dx == '0) && (r_s0_dz == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_c1_vld[0] <= r_s0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c1_x[0]    <= n_x0;
            r_c1_y[0]    <= n_y0;
            r_c1_z[0]    <= n_z0;
            r_c1_pole[0] <= w_pole;
            r_c1_zero[0] <= w_pole && (r_s0_dy == '0);
            r_s1_prod    <= P_W'(w_aby) * P_W'(GAIN_Q30);
            r_s1_neg     <= r_s0_dy[D_W-1];
        end
    end

    // azimuth cordic: one iteration per stage, g*dy travels alongside
    for (genvar k = 1; k <= N; k++) begin : g_c1
        logic signed [XY_W-1:0] w_xs, w_ys, n_x, n_y, n_ky;
        logic signed [Z_W-1:0]  n_z, w_at;

        always_comb begin
            w_xs = r_c1_x[k-1] >>> (k - 1);
            w_ys = r_c1_y[k-1] >>> (k - 1);
            w_at = Z_W'(ATAN_TAB[k-1]);
            if (!r_c1_y[k-1][XY_W-1]) begin
                n_x = r_c1_x[k-1] + w_ys;
                n_y = r_c1_y[k-1] - w_xs;
                n_z = r_c1_z[k-1] + w_at;
            end else begin
                n_x = r_c1_x[k-1] - w_ys;
                n_y = r_c1_y[k-1] + w_xs;
                n_z = r_c1_z[k-1] - w_at;
            end
        end

        // first stage turns the product into signed g*dy
        if (k == 1) begin : g_ky0
            always_comb begin
                n_ky = XY_W'(r_s1_prod[P_W-1:30]);
                if (r_s1_neg) begin
                    n_ky = -n_ky;
                end
            end
        end else begin : g_kyn
            assign n_ky = r_ky[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c1_vld[k] <= 1'b0;
            end else if (w_adv) begin
                r_c1_vld[k] <= r_c1_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_c1_x[k]    <= n_x;
                r_c1_y[k]    <= n_y;
                r_c1_z[k]    <= n_z;
                r_ky[k]      <= n_ky;
                r_c1_pole[k] <= r_c1_pole[k-1];
                r_c1_zero[k] <= r_c1_zero[k-1];
            end
        end
    end

    // wrapped azimuth, forced to zero at the poles
    logic signed [31:0] w_theta;
    assign w_theta = r_c1_pole[N] ? 32'sd0 : r_c1_z[N][31:0];

    // elevation cordic on (length, g*dy)
    logic                   r_c2_vld   [1:N];
    logic                   r_c2_zero  [1:N];
    logic signed [31:0]     r_c2_theta [1:N];
    logic signed [XY_W-1:0] r_c2_x     [1:N];
    logic signed [XY_W-1:0] r_c2_y     [1:N];
    logic signed [Z_W-1:0]  r_c2_z     [1:N];

    for (genvar k = 1; k <= N; k++) begin : g_c2
        logic                   w_vld, w_zero;
        logic signed [31:0]     w_th;
        logic signed [XY_W-1:0] w_x, w_y, w_xs, w_ys, n_x, n_y;
        logic signed [Z_W-1:0]  w_z, n_z, w_at;

        if (k == 1) begin : g_in0
            assign w_vld  = r_c1_vld[N];
            assign w_zero = r_c1_zero[N];
            assign w_th   = w_theta;
            assign w_x    = r_c1_x[N];
            assign w_y    = r_ky[N];
            assign w_z    = '0;
        end else begin : g_inn
            assign w_vld  = r_c2_vld[k-1];
            assign w_zero = r_c2_zero[k-1];
            assign w_th   = r_c2_theta[k-1];
            assign w_x    = r_c2_x[k-1];
            assign w_y    = r_c2_y[k-1];
            assign w_z    = r_c2_z[k-1];
        end

        always_comb begin
            w_xs = w_x >>> (k - 1);
            w_ys = w_y >>> (k - 1);
            w_at = Z_W'(ATAN_TAB[k-1]);
            if (!w_y[XY_W-1]) begin
                n_x = w_x + w_ys;
                n_y = w_y - w_xs;
                n_z = w_z + w_at;
            end else begin
                n_x = w_x - w_ys;
                n_y = w_y + w_xs;
                n_z = w_z - w_at;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c2_vld[k] <= 1'b0;
            end else if (w_adv) begin
                r_c2_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_c2_x[k]     <= n_x;
                r_c2_y[k]     <= n_y;
                r_c2_z[k]     <= n_z;
                r_c2_zero[k]  <= w_zero;
                r_c2_theta[k] <= w_th;
            end
        end
    end

    // angle to texture coordinate conversion
    logic [Z_W:0]          w_unum, w_vnum;
    logic signed [Z_W:0]   w_phi;
    logic [OUT_W-1:0]      n_u, n_v;

    always_comb begin
        w_unum = (Z_W + 1)'(HALF_TURN - (Z_W + 1)'(r_c2_theta[N])) + U_ROUND;
        w_phi  = (Z_W + 1)'(r_c2_z[N]) + (Z_W + 1)'(QUARTER);
        if (w_phi < 0) begin
            w_phi = '0;
        end else if (w_phi > HALF_TURN) begin
            w_phi = HALF_TURN;
        end
        w_vnum = (Z_W + 1)'(w_phi) + V_ROUND;
        n_u    = OUT_W'(w_unum >> U_SHIFT);
        n_v    = OUT_W'(w_vnum >> V_SHIFT);
        if (r_c2_zero[N]) begin
            n_u = HALF_CODE;
            n_v = HALF_CODE;
        end
    end

    // output register
    logic [OUT_W-1:0] r_o_u, r_o_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            r_o_valid <= r_c2_vld[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_u <= n_u;
            r_o_v <= n_v;
        end
    end

    assign o_valid   = r_o_valid;
    assign o_u_coord = r_o_u;
    assign o_v_coord = r_o_v;

endmodule
